FILE: hw/rtl/bscur_pkg.sv
// shared types, constants and helpers for the bright spot cursor tracker
package bscur_pkg;

   localparam int FRAME_WIDTH  = 480;
   localparam int FRAME_HEIGHT = 272;

   localparam int OUT_W      = 9;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_INDEX_W = 1;

   // coordinates must hold the frame size and the reset cursor
   localparam int COL_BITS = $clog2(FRAME_WIDTH);
   localparam int ROW_BITS = $clog2(FRAME_HEIGHT);
   localparam int DIM_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
   localparam int COORD_W  = (DIM_BITS > OUT_W) ? DIM_BITS : OUT_W;
   localparam int DIFF_W   = COORD_W + 2;

   typedef logic [COORD_W-1:0] coord_type;

   localparam coord_type COL_LAST = COORD_W'(FRAME_WIDTH - 1);
   localparam coord_type ROW_LAST = COORD_W'(FRAME_HEIGHT - 1);

   localparam coord_type CURSOR_X_RESET = COORD_W'(237);
   localparam coord_type CURSOR_Y_RESET = COORD_W'(50);

   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET = CSR_DATA_W'(200);
   localparam logic [CSR_DATA_W-1:0] DEAD_ZONE_RESET = CSR_DATA_W'(4);

   // luma weights; 1000 * 255 fits in 18 bits
   localparam int LUMA_SUM_W = 18;
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_R = LUMA_SUM_W'(299);
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_G = LUMA_SUM_W'(587);
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_B = LUMA_SUM_W'(114);
   localparam logic [LUMA_SUM_W-1:0] LUMA_DIV = LUMA_SUM_W'(1000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LUMA_THRESHOLD = 1'b0,
      CSR_DEAD_ZONE      = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      HEAD_NONE = 4'd0,
      HEAD_W    = 4'd1,
      HEAD_NW   = 4'd2,
      HEAD_N    = 4'd3,
      HEAD_NE   = 4'd4,
      HEAD_E    = 4'd5,
      HEAD_SE   = 4'd6,
      HEAD_S    = 4'd7,
      HEAD_SW   = 4'd8
   } heading_type;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_NEG  = 2'd1,
      AXIS_POS  = 2'd2
   } axis_type;

   typedef struct packed {
      logic      found;
      coord_type min_col;
      coord_type min_row;
      coord_type max_col;
      coord_type max_row;
   } box_type;

   typedef struct packed {
      coord_type   cursor_x;
      coord_type   cursor_y;
      heading_type heading;
      box_type     box;
   } result_type;

   // x class picks the compass side, y class north or south
   function automatic heading_type heading_lookup(axis_type xc, axis_type yc);
      heading_type h;
      h = HEAD_NONE;
      unique case (xc)
         AXIS_NEG: begin
            unique case (yc)
               AXIS_NEG: h = HEAD_NW;
               AXIS_POS: h = HEAD_SW;
               default:  h = HEAD_W;
            endcase
         end
         AXIS_POS: begin
            unique case (yc)
               AXIS_NEG: h = HEAD_NE;
               AXIS_POS: h = HEAD_SE;
               default:  h = HEAD_E;
            endcase
         end
         default: begin
            unique case (yc)
               AXIS_NEG: h = HEAD_N;
               AXIS_POS: h = HEAD_S;
               default:  h = HEAD_NONE;
            endcase
         end
      endcase
      return h;
   endfunction

endpackage

FILE: hw/rtl/bscur_luma.sv
// luma threshold test of one pixel
module bscur_luma (
   input  logic [7:0]                          red,
   input  logic [7:0]                          green,
   input  logic [7:0]                          blue,
   input  logic [bscur_pkg::CSR_DATA_W-1:0]    threshold,
   output logic                                bright
);
   import bscur_pkg::*;

   logic [LUMA_SUM_W-1:0] sum;
   logic [LUMA_SUM_W-1:0] limit;

   // luma / 1000 > t  is the same as  sum >= 1000 * (t + 1)
   assign sum = WEIGHT_R * LUMA_SUM_W'(red) + WEIGHT_G * LUMA_SUM_W'(green)
              + WEIGHT_B * LUMA_SUM_W'(blue);
   assign limit = LUMA_DIV * (LUMA_SUM_W'(threshold) + LUMA_SUM_W'(1));
   assign bright = (sum >= limit);

endmodule

FILE: hw/rtl/bscur_box.sv
// raster position counters, bounding box accumulation and end-of-frame capture
module bscur_box (
   input  logic                clock,
   input  logic                reset,
   input  logic                pix_valid,
   input  logic                pix_eof,
   input  logic                pix_bright,
   input  logic                cap_take,
   output logic                pix_ready,
   output logic                cap_valid,
   output bscur_pkg::box_type  cap_box
);
   import bscur_pkg::*;

   coord_type col_ff, col_in;
   coord_type row_ff, row_in;
   box_type   box_ff, box_in;
   box_type   box_upd;
   logic      cap_valid_ff, cap_valid_in;
   box_type   cap_box_ff, cap_box_in;
   logic      fire;

   always_comb begin
      box_upd = box_ff;
      if (pix_bright) begin
         if (!box_ff.found) begin
            box_upd.found   = 1'b1;
            box_upd.min_col = col_ff;
            box_upd.max_col = col_ff;
            box_upd.min_row = row_ff;
            box_upd.max_row = row_ff;
         end else begin
            if (col_ff < box_ff.min_col) box_upd.min_col = col_ff;
            if (col_ff > box_ff.max_col) box_upd.max_col = col_ff;
            if (row_ff < box_ff.min_row) box_upd.min_row = row_ff;
            if (row_ff > box_ff.max_row) box_upd.max_row = row_ff;
         end
      end
   end

   // only a last pixel needs room in the capture register
   assign pix_ready = !pix_eof || !cap_valid_ff || cap_take;
   assign fire      = pix_valid && pix_ready;

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      box_in       = box_ff;
      cap_valid_in = cap_valid_ff;
      cap_box_in   = cap_box_ff;
      if (cap_take) begin
         cap_valid_in = 1'b0;
      end
      if (fire) begin
         if (pix_eof) begin
            col_in       = '0;
            row_in       = '0;
            box_in       = '0;
            cap_valid_in = 1'b1;
            cap_box_in   = box_upd;
         end else begin
            box_in = box_upd;
            if (col_ff == COL_LAST) begin
               col_in = '0;
               row_in = (row_ff == ROW_LAST) ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         box_ff       <= '0;
         cap_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         box_ff       <= box_in;
         cap_valid_ff <= cap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_box_ff <= cap_box_in;
   end

   assign cap_valid = cap_valid_ff;
   assign cap_box   = cap_box_ff;

   a_cap_held: assert property (@(posedge clock) disable iff (reset)
      cap_valid_ff && !cap_take |=> cap_valid_ff && $stable(cap_box_ff))
      else $error("captured box lost or changed before being taken");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      box_ff.found |-> (box_ff.min_col <= box_ff.max_col) && (box_ff.min_row <= box_ff.max_row))
      else $error("bounding box corners out of order");

   a_box_empty: assert property (@(posedge clock) disable iff (reset)
      !box_ff.found |-> (box_ff == '0) && (col_ff <= COL_LAST) && (row_ff <= ROW_LAST))
      else $error("empty box not cleared or position out of frame");

endmodule

FILE: hw/rtl/bscur_heading.sv
// movement classification, cursor choice and result register
module bscur_heading (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cap_valid,
   input  bscur_pkg::box_type                 cap_box,
   input  logic [bscur_pkg::CSR_DATA_W-1:0]   dead_zone,
   input  logic                               rsp_stall,
   output logic                               cap_take,
   output logic                               rsp_valid,
   output bscur_pkg::result_type              rsp_result
);
   import bscur_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_result_ff, rsp_result_in;
   coord_type   prev_x_ff, prev_x_in;
   coord_type   prev_y_ff, prev_y_in;
   heading_type last_head_ff, last_head_in;

   logic [COORD_W:0]          sum_x, sum_y;
   coord_type                 mid_x, mid_y;
   logic signed [DIFF_W-1:0]  diff_x, diff_y, span;
   axis_type                  class_x, class_y;
   heading_type               head;
   coord_type                 cur_x, cur_y;

   function automatic axis_type classify(logic signed [DIFF_W-1:0] d,
                                         logic signed [DIFF_W-1:0] s);
      axis_type c;
      // negative side wins when the dead zone is zero
      priority if (d <= -s) c = AXIS_NEG;
      else if (d >= s)      c = AXIS_POS;
      else                  c = AXIS_NONE;
      return c;
   endfunction

   assign cap_take = cap_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sum_x   = {1'b0, cap_box.min_col} + {1'b0, cap_box.max_col};
      sum_y   = {1'b0, cap_box.min_row} + {1'b0, cap_box.max_row};
      mid_x   = sum_x[COORD_W:1];
      mid_y   = sum_y[COORD_W:1];
      diff_x  = $signed({2'b00, mid_x}) - $signed({2'b00, prev_x_ff});
      diff_y  = $signed({2'b00, mid_y}) - $signed({2'b00, prev_y_ff});
      span    = $signed(DIFF_W'(dead_zone));
      class_x = classify(diff_x, span);
      class_y = classify(diff_y, span);
      head    = heading_lookup(class_x, class_y);
      unique case (head)
         HEAD_W:  begin cur_x = cap_box.min_col; cur_y = mid_y;           end
         HEAD_NW: begin cur_x = cap_box.min_col; cur_y = cap_box.min_row; end
         HEAD_N:  begin cur_x = mid_x;           cur_y = cap_box.min_row; end
         HEAD_NE: begin cur_x = cap_box.max_col; cur_y = cap_box.min_row; end
         HEAD_E:  begin cur_x = cap_box.max_col; cur_y = mid_y;           end
         HEAD_SE: begin cur_x = cap_box.max_col; cur_y = cap_box.max_row; end
         HEAD_S:  begin cur_x = mid_x;           cur_y = cap_box.max_row; end
         HEAD_SW: begin cur_x = cap_box.min_col; cur_y = cap_box.max_row; end
         default: begin cur_x = prev_x_ff;       cur_y = prev_y_ff;       end
      endcase
      // no bright pixel: keep the old cursor and repeat the old heading
      if (!cap_box.found) begin
         head  = last_head_ff;
         cur_x = prev_x_ff;
         cur_y = prev_y_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      last_head_in  = last_head_ff;
      if (cap_take) begin
         rsp_valid_in           = 1'b1;
         rsp_result_in.cursor_x = cur_x;
         rsp_result_in.cursor_y = cur_y;
         rsp_result_in.heading  = head;
         rsp_result_in.box      = cap_box;
         prev_x_in              = cur_x;
         prev_y_in              = cur_y;
         last_head_in           = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_x_ff    <= CURSOR_X_RESET;
         prev_y_ff    <= CURSOR_Y_RESET;
         last_head_ff <= HEAD_NONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         last_head_ff <= last_head_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      cap_take |=> rsp_valid_ff && (rsp_result_ff.cursor_x == prev_x_ff)
                   && (rsp_result_ff.heading == last_head_ff))
      else $error("taken frame not shown or cursor history out of step");

   a_history_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(prev_x_ff) && $stable(prev_y_ff))
      else $error("cursor history moved while a result was waiting");

endmodule

FILE: hw/rtl/bright_spot_cursor_tracker_unit.sv
// Bright spot cursor tracker: takes one RGB pixel per clock in raster order, keeps the
// bounding box of pixels whose luma exceeds the threshold and, on the pixel flagged
// end_of_frame, returns the box and a cursor picked from it by the direction of movement
// against the previous cursor. Throughput is one pixel per clock while req_stall is low,
// set by the pixel path (input register, box accumulator); the end-of-frame pixel moves
// on through the capture and result registers. Pixels keep flowing while a result waits;
// only an end-of-frame pixel is held back, and only while two earlier results are untaken.
module bright_spot_cursor_tracker_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_red,
   input  logic [7:0]                           req_green,
   input  logic [7:0]                           req_blue,
   input  logic                                 req_end_of_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bscur_pkg::OUT_W-1:0]          rsp_cursor_x,
   output logic [bscur_pkg::OUT_W-1:0]          rsp_cursor_y,
   output logic [3:0]                           rsp_heading,
   output logic                                 rsp_spot_found,
   output logic [bscur_pkg::OUT_W-1:0]          rsp_box_left,
   output logic [bscur_pkg::OUT_W-1:0]          rsp_box_top,
   output logic [bscur_pkg::OUT_W-1:0]          rsp_box_right,
   output logic [bscur_pkg::OUT_W-1:0]          rsp_box_bottom,
   input  logic                                 csr_write,
   input  logic [bscur_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bscur_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bscur_pkg::*;

   logic [CSR_DATA_W-1:0] threshold_ff, threshold_in;
   logic [CSR_DATA_W-1:0] dead_zone_ff, dead_zone_in;

   logic       pix_valid_ff, pix_valid_in;
   logic       pix_bright_ff, pix_bright_in;
   logic       pix_eof_ff, pix_eof_in;
   logic       req_bright;
   logic       pix_ready;
   logic       req_take;

   logic       cap_valid;
   box_type    cap_box;
   logic       cap_take;
   result_type rsp_result;

   always_comb begin
      threshold_in = threshold_ff;
      dead_zone_in = dead_zone_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_LUMA_THRESHOLD: threshold_in = csr_data;
            CSR_DEAD_ZONE:      dead_zone_in = csr_data;
         endcase
      end
   end

   bscur_luma u_luma (
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .threshold (threshold_ff),
      .bright    (req_bright)
   );

   // input register holds the bright flag rather than the raw colour
   assign req_stall = pix_valid_ff && !pix_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      pix_valid_in  = pix_valid_ff && !pix_ready;
      pix_bright_in = pix_bright_ff;
      pix_eof_in    = pix_eof_ff;
      if (req_take) begin
         pix_valid_in  = 1'b1;
         pix_bright_in = req_bright;
         pix_eof_in    = req_end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         dead_zone_ff <= DEAD_ZONE_RESET;
         pix_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         dead_zone_ff <= dead_zone_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_bright_ff <= pix_bright_in;
      pix_eof_ff    <= pix_eof_in;
   end

   bscur_box u_box (
      .clock      (clock),
      .reset      (reset),
      .pix_valid  (pix_valid_ff),
      .pix_eof    (pix_eof_ff),
      .pix_bright (pix_bright_ff),
      .cap_take   (cap_take),
      .pix_ready  (pix_ready),
      .cap_valid  (cap_valid),
      .cap_box    (cap_box)
   );

   bscur_heading u_heading (
      .clock      (clock),
      .reset      (reset),
      .cap_valid  (cap_valid),
      .cap_box    (cap_box),
      .dead_zone  (dead_zone_ff),
      .rsp_stall  (rsp_stall),
      .cap_take   (cap_take),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_cursor_x   = rsp_result.cursor_x[OUT_W-1:0];
   assign rsp_cursor_y   = rsp_result.cursor_y[OUT_W-1:0];
   assign rsp_heading    = rsp_result.heading;
   assign rsp_spot_found = rsp_result.box.found;
   assign rsp_box_left   = rsp_result.box.min_col[OUT_W-1:0];
   assign rsp_box_top    = rsp_result.box.min_row[OUT_W-1:0];
   assign rsp_box_right  = rsp_result.box.max_col[OUT_W-1:0];
   assign rsp_box_bottom = rsp_result.box.max_row[OUT_W-1:0];

endmodule
